FILE: sv/scd_pkg.sv
package scd_pkg;

  localparam int unsigned CmdW    = 8;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned SampleW = 5;
  localparam int unsigned TicksW  = 16;

  localparam logic [TicksW-1:0] TICKS_RESET = 16'd100;

  // request kinds on the slave side
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // result action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STOP  = 1'b1;

  localparam logic [ChanW-1:0] CHAN_QUEUED = 2'd2;
  localparam logic [ChanW-1:0] CHAN_MUSIC  = 2'd3;

  // decoded command kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_PLAY  = 3'd2;
  localparam logic [2:0] KIND_MUSIC = 3'd3;
  localparam logic [2:0] KIND_QUEUE = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [SampleW-1:0] sample;
    logic               loop_flag;
  } decode_t;

  function automatic decode_t decode_cmd(input logic [CmdW-1:0] cmd);
    decode_t d;
    d.kind      = KIND_NONE;
    d.sample    = '0;
    d.loop_flag = 1'b0;
    case (cmd)
      8'd0:   d.kind = KIND_STOP;
      8'd1:   begin d.kind = KIND_QUEUE; d.sample = 5'd0;  end
      8'd4:   begin d.kind = KIND_QUEUE; d.sample = 5'd1;  end
      8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12: begin
        d.kind   = KIND_PLAY;
        d.sample = SampleW'(cmd - 8'd3);
      end
      8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71: begin
        d.kind      = KIND_MUSIC;
        d.sample    = SampleW'(cmd - 8'd54);
        d.loop_flag = (cmd == 8'd65) || (cmd == 8'd66) || (cmd == 8'd67) || (cmd == 8'd71);
      end
      8'd128: begin d.kind = KIND_PLAY;  d.sample = 5'd18; end
      8'd129: begin d.kind = KIND_PLAY;  d.sample = 5'd19; end
      8'd131: begin d.kind = KIND_PLAY;  d.sample = 5'd20; end
      8'd133: begin d.kind = KIND_PLAY;  d.sample = 5'd21; end
      8'd135: begin d.kind = KIND_QUEUE; d.sample = 5'd22; end
      8'd136: begin d.kind = KIND_QUEUE; d.sample = 5'd23; end
      8'd153: begin d.kind = KIND_QUEUE; d.sample = 5'd24; end
      default: d.kind = KIND_NONE;
    endcase
    return d;
  endfunction

endpackage

FILE: sv/sound_command_dispatcher.sv
// Sound command dispatcher. Each request on the slave side is either a CPU
// sound command byte (tuser 0) or one timer tick (tuser 1). Commands decode
// into stop-all, an immediate effect (alternating channels 0 and 1), music on
// channel 3, or a queued effect held in a two-entry queue (dropped when full).
// Ticks count down the wait counter and, once it is idle, start the queued
// head on channel 2 and reload the counter from cfg_wdata's last write (reset
// value 100). A request is taken every cycle the output register is empty or
// being drained; decode and state update finish in that same cycle, and the
// result, if any, appears on the master side in the next cycle. Throughput is
// one request per clock, limited only by back-pressure on the master side.
module sound_command_dispatcher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [scd_pkg::CmdW-1:0]            s_axis_tdata,  // [7:0] command
  input  logic                                s_axis_tuser,  // [0] opcode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] channel, [6:2] sample_index, [7] loop_flag
  output logic [7:0]                          m_axis_tdata,
  output logic                                m_axis_tuser,  // [0] action
  input  logic                                cfg_we,
  input  logic [scd_pkg::TicksW-1:0]          cfg_wdata
);
  import scd_pkg::*;

  logic [TicksW-1:0]  queued_sound_ticks;
  logic               head_valid;
  logic [SampleW-1:0] head_sample;
  logic               tail_valid;
  logic [SampleW-1:0] tail_sample;
  logic [TicksW-1:0]  wait_counter;
  logic               next_chan;

  logic               out_action;
  logic [ChanW-1:0]   out_chan;
  logic [SampleW-1:0] out_sample;
  logic               out_loop;

  logic    accept;
  decode_t dec;
  logic    res_valid;
  logic    res_action;
  logic [ChanW-1:0]   res_chan;
  logic [SampleW-1:0] res_sample;
  logic               res_loop;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign dec           = decode_cmd(s_axis_tdata);

  always_comb begin
    res_valid  = 1'b0;
    res_action = ACT_START;
    res_chan   = '0;
    res_sample = '0;
    res_loop   = 1'b0;
    if (s_axis_tuser == OP_TICK) begin
      if (wait_counter == '0 && head_valid) begin
        res_valid  = 1'b1;
        res_chan   = CHAN_QUEUED;
        res_sample = head_sample;
      end
    end else begin
      case (dec.kind)
        KIND_STOP: begin
          res_valid  = 1'b1;
          res_action = ACT_STOP;
        end
        KIND_PLAY: begin
          res_valid  = 1'b1;
          res_chan   = {1'b0, next_chan};
          res_sample = dec.sample;
        end
        KIND_MUSIC: begin
          res_valid  = 1'b1;
          res_chan   = CHAN_MUSIC;
          res_sample = dec.sample;
          res_loop   = dec.loop_flag;
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queued_sound_ticks <= TICKS_RESET;
      head_valid         <= 1'b0;
      tail_valid         <= 1'b0;
      wait_counter       <= '0;
      next_chan          <= 1'b0;
      m_axis_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        queued_sound_ticks <= cfg_wdata;
      end
      if (accept) begin
        m_axis_tvalid <= res_valid;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (accept) begin
        if (s_axis_tuser == OP_TICK) begin
          if (wait_counter != '0) begin
            wait_counter <= wait_counter - 1'b1;
          end else if (head_valid) begin
            // start head, shift tail forward
            wait_counter <= queued_sound_ticks;
            head_valid   <= tail_valid;
            tail_valid   <= 1'b0;
          end
        end else begin
          if (dec.kind == KIND_PLAY) begin
            next_chan <= ~next_chan;
          end
          if (dec.kind == KIND_QUEUE) begin
            if (!head_valid) begin
              head_valid <= 1'b1;
            end else if (!tail_valid) begin
              tail_valid <= 1'b1;
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_action <= res_action;
      out_chan   <= res_chan;
      out_sample <= res_sample;
      out_loop   <= res_loop;
    end
    if (accept) begin
      if (s_axis_tuser == OP_TICK) begin
        if (wait_counter == '0 && head_valid) begin
          head_sample <= tail_sample;
          tail_sample <= '0;
        end
      end else if (dec.kind == KIND_QUEUE) begin
        if (!head_valid) begin
          head_sample <= dec.sample;
        end else if (!tail_valid) begin
          tail_sample <= dec.sample;
        end
      end
    end
  end

  assign m_axis_tuser = out_action;
  assign m_axis_tdata = {out_loop, out_sample, out_chan};

endmodule
